[rtl/burh_pkg.sv]
// Shared types and constants for the bounded undo/redo history block.
package burh_pkg;

  localparam int HISTORY_DEPTH_DEF = 256;
  localparam int HANDLE_BITS_DEF   = 16;
  localparam int TARGET_BITS       = 16;
  localparam int DEPTH_BITS        = 9;

  typedef enum logic [1:0] {
    OP_EXECUTE = 2'd0,
    OP_UNDO    = 2'd1,
    OP_REDO    = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_UNDO = 2'd1,
    ACT_REDO = 2'd2
  } action_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_cmd_t;

endpackage

[rtl/bounded_undo_redo_history_core.sv]
// Top level of the bounded undo/redo history block.
//
// Request channel (req_valid/req_ready): opcode, handle, succeeded.
// Result channel (rsp_valid/rsp_ready): action, target, undo_depth, redo_depth.
// Every request gives exactly one result, in request order.
//
// A request's popped stack top is read from its store at the edge that accepts
// the request; the middle stage then writes it (or an executed handle) into the
// destination store and loads the result register once that register is free.
// Throughput: one request per cycle while results are taken, set by the single
// write port and registered read port of each store; a pop of an entry that
// the previous request is still writing takes the value from a bypass.
//
// Reset empties both histories and drops any request or result in flight.
// The stores themselves are not cleared: the fill counts cover every read.
// When the receiver stalls, the result register holds, the middle stage
// holds behind it, and once it is full req_ready falls until the result is taken.
module bounded_undo_redo_history_core #(
  parameter int HISTORY_DEPTH = burh_pkg::HISTORY_DEPTH_DEF,
  parameter int HANDLE_BITS   = burh_pkg::HANDLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  burh_pkg::opcode_t                opcode,
  input  logic [HANDLE_BITS-1:0]           handle,
  input  logic                             succeeded,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output burh_pkg::action_t                action,
  output logic [burh_pkg::TARGET_BITS-1:0] target,
  output logic [burh_pkg::DEPTH_BITS-1:0]  undo_depth,
  output logic [burh_pkg::DEPTH_BITS-1:0]  redo_depth
);
  import burh_pkg::*;

  localparam int TW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  logic                   accept;
  stk_cmd_t               u_cmd;
  stk_cmd_t               r_cmd;
  logic [TW-1:0]          u_push_addr;
  logic [TW-1:0]          u_pop_addr;
  logic                   u_empty;
  logic [CW-1:0]          u_count_next;
  logic [TW-1:0]          r_push_addr;
  logic [TW-1:0]          r_pop_addr;
  logic                   r_empty;
  logic [CW-1:0]          r_count_next;
  action_t                act_next;
  logic                   fwd_next;

  logic                   s1_valid;
  action_t                s1_action;
  logic                   s1_wr_undo;
  logic                   s1_wr_redo;
  logic [TW-1:0]          s1_waddr;
  logic                   s1_exec;
  logic                   s1_from_undo;
  logic [HANDLE_BITS-1:0] s1_handle;
  logic                   s1_fwd;
  logic [HANDLE_BITS-1:0] s1_fwd_data;
  logic [CW-1:0]          s1_undo_cnt;
  logic [CW-1:0]          s1_redo_cnt;
  logic [HANDLE_BITS-1:0] s1_data;
  logic                   s1_adv;
  logic                   s1_go;

  logic                   u_we;
  logic                   r_we;
  logic [HANDLE_BITS-1:0] u_rdata;
  logic [HANDLE_BITS-1:0] r_rdata;

  assign s1_adv    = !rsp_valid || rsp_ready;
  assign s1_go     = s1_valid && s1_adv;
  assign req_ready = !s1_valid || s1_adv;
  assign accept    = req_valid && req_ready;

  always_comb begin
    u_cmd    = '0;
    r_cmd    = '0;
    act_next = ACT_NONE;
    unique case (opcode)
      OP_EXECUTE: begin
        u_cmd.push  = succeeded;
        r_cmd.clear = 1'b1;
      end
      OP_UNDO: begin
        u_cmd.pop  = !u_empty;
        r_cmd.push = !u_empty;
        if (!u_empty) begin
          act_next = ACT_UNDO;
        end
      end
      OP_REDO: begin
        r_cmd.pop  = !r_empty;
        u_cmd.push = !r_empty;
        if (!r_empty) begin
          act_next = ACT_REDO;
        end
      end
      OP_CLEAR: begin
        u_cmd.clear = 1'b1;
        r_cmd.clear = 1'b1;
      end
      default: begin
        u_cmd.clear = 1'b1;
        r_cmd.clear = 1'b1;
      end
    endcase
  end

  burh_ptr #(.DEPTH(HISTORY_DEPTH)) u_undo_ptr (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .cmd        (u_cmd),
    .push_addr  (u_push_addr),
    .pop_addr   (u_pop_addr),
    .empty      (u_empty),
    .count_next (u_count_next)
  );

  burh_ptr #(.DEPTH(HISTORY_DEPTH)) u_redo_ptr (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .cmd        (r_cmd),
    .push_addr  (r_push_addr),
    .pop_addr   (r_pop_addr),
    .empty      (r_empty),
    .count_next (r_count_next)
  );

  // bypass a pop of the slot that the middle stage writes at this edge
  assign fwd_next = ((opcode == OP_UNDO) && u_we && (s1_waddr == u_pop_addr)) ||
                    ((opcode == OP_REDO) && r_we && (s1_waddr == r_pop_addr));

  assign s1_data = s1_fwd  ? s1_fwd_data :
                   s1_exec ? s1_handle   :
                   s1_from_undo ? u_rdata : r_rdata;

  assign u_we = s1_go && s1_wr_undo;
  assign r_we = s1_go && s1_wr_redo;

  burh_ram #(.DEPTH(HISTORY_DEPTH), .WIDTH(HANDLE_BITS)) u_undo_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (s1_waddr),
    .wdata (s1_data),
    .re    (accept),
    .raddr (u_pop_addr),
    .rdata (u_rdata)
  );

  burh_ram #(.DEPTH(HISTORY_DEPTH), .WIDTH(HANDLE_BITS)) u_redo_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (s1_waddr),
    .wdata (s1_data),
    .re    (accept),
    .raddr (r_pop_addr),
    .rdata (r_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action    <= act_next;
      s1_wr_undo   <= u_cmd.push;
      s1_wr_redo   <= r_cmd.push;
      s1_waddr     <= u_cmd.push ? u_push_addr : r_push_addr;
      s1_exec      <= (opcode == OP_EXECUTE);
      s1_from_undo <= (opcode == OP_UNDO);
      s1_handle    <= handle;
      s1_fwd       <= fwd_next;
      s1_fwd_data  <= s1_data;
      s1_undo_cnt  <= u_count_next;
      s1_redo_cnt  <= r_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      action     <= s1_action;
      target     <= (s1_action == ACT_NONE) ? '0 : TARGET_BITS'(s1_data);
      undo_depth <= DEPTH_BITS'(s1_undo_cnt);
      redo_depth <= DEPTH_BITS'(s1_redo_cnt);
    end
  end

endmodule

[rtl/burh_ram.sv]
// History store: one write port, one registered read port.
module burh_ram #(
  parameter int DEPTH = burh_pkg::HISTORY_DEPTH_DEF,
  parameter int WIDTH = burh_pkg::HANDLE_BITS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  import burh_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/burh_ptr.sv]
// Ring pointer and fill count of one bounded history stack.
module burh_ptr #(
  parameter int DEPTH = burh_pkg::HISTORY_DEPTH_DEF,
  localparam int TW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  burh_pkg::stk_cmd_t cmd,
  output logic [TW-1:0]      push_addr,
  output logic [TW-1:0]      pop_addr,
  output logic               empty,
  output logic [CW-1:0]      count_next
);
  import burh_pkg::*;

  logic [TW-1:0] top;
  logic [TW-1:0] top_next;
  logic [TW-1:0] top_inc;
  logic [TW-1:0] top_dec;
  logic [CW-1:0] count;

  assign top_inc   = (top == TW'(DEPTH - 1)) ? '0 : top + 1'b1;
  assign top_dec   = (top == '0) ? TW'(DEPTH - 1) : top - 1'b1;
  assign push_addr = top;
  assign pop_addr  = top_dec;
  assign empty     = (count == '0);

  always_comb begin
    top_next   = top;
    count_next = count;
    priority if (cmd.clear) begin
      top_next   = '0;
      count_next = '0;
    end else if (cmd.push) begin
      top_next = top_inc;
      if (count != CW'(DEPTH)) begin
        count_next = count + 1'b1;
      end
    end else if (cmd.pop && !empty) begin
      top_next   = top_dec;
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top   <= '0;
      count <= '0;
    end else if (en) begin
      top   <= top_next;
      count <= count_next;
    end
  end

endmodule

[rtl/burh_checker.sv]
// Port-level checks on the undo/redo history result channel, bound to the top level.
module burh_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [1:0]                       action,
  input logic [burh_pkg::TARGET_BITS-1:0] target,
  input logic [burh_pkg::DEPTH_BITS-1:0]  undo_depth,
  input logic [burh_pkg::DEPTH_BITS-1:0]  redo_depth
);
  import burh_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(action) && $stable(target) &&
      $stable(undo_depth) && $stable(redo_depth))
    else $error("stalled result changed");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (action == ACT_NONE) |-> (target == '0))
    else $error("target not zero with no action");

  a_undo_depth: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (action == ACT_UNDO) |-> (redo_depth != '0))
    else $error("undo reported with empty redo history");

  a_redo_depth: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (action == ACT_REDO) |-> (undo_depth != '0))
    else $error("redo reported with empty undo history");

endmodule

bind bounded_undo_redo_history_core burh_checker u_burh_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp_valid),
  .rsp_ready  (rsp_ready),
  .action     (action),
  .target     (target),
  .undo_depth (undo_depth),
  .redo_depth (redo_depth)
);
